### design/dq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies

package dq_pkg;

    localparam int DQ_DEPTH     = 16;
    localparam int DQ_ELEM_BITS = 8;
    localparam int DQ_OP_W      = 3;
    localparam int DQ_VAL_W     = 8;
    localparam int DQ_CNT_W     = 5;
    localparam int DQ_ST_W      = 2;

    typedef enum logic [DQ_OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_QUERY      = 3'd5
    } t_dq_op;

    typedef enum logic [DQ_ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_dq_status;

    typedef struct packed {
        logic [DQ_OP_W-1:0]  op;
        logic [DQ_VAL_W-1:0] value;
    } t_dq_in;

    typedef struct packed {
        logic [DQ_VAL_W-1:0] front_value;
        logic                front_valid;
        logic [DQ_VAL_W-1:0] back_value;
        logic                back_valid;
        logic [DQ_CNT_W-1:0] count;
        logic [DQ_ST_W-1:0]  status;
    } t_dq_out;

    // per-word status from the pointer control to the result stage
    typedef struct packed {
        logic       nonempty;
        t_dq_status status;
    } t_dq_ctl;

endpackage

### design/dq_ram.sv
// ring store: one write port, two registered read ports
// uses dq_pkg only through its parameter defaults at the top level

module dq_ram #(
    parameter int DEPTH     = 16,
    parameter int ELEM_BITS = 8,
    parameter int ADDR_W    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  logic [ELEM_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr_f,
    input  logic [ADDR_W-1:0]    i_raddr_b,
    output logic [ELEM_BITS-1:0] o_rdata_f,
    output logic [ELEM_BITS-1:0] o_rdata_b
);

    logic [ELEM_BITS-1:0] r_mem [DEPTH];
    logic [ELEM_BITS-1:0] r_rdata_f;
    logic [ELEM_BITS-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read with forwarding of a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr_f)) begin
                r_rdata_f <= i_wdata;
            end else begin
                r_rdata_f <= r_mem[i_raddr_f];
            end
            if (i_we && (i_waddr == i_raddr_b)) begin
                r_rdata_b <= i_wdata;
            end else begin
                r_rdata_b <= r_mem[i_raddr_b];
            end
        end
    end

    assign o_rdata_f = r_rdata_f;
    assign o_rdata_b = r_rdata_b;

endmodule

### design/dq_ctrl.sv
// front/back pointers and element count, op decode
// depends on dq_pkg

module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int CNT_W  = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [DQ_OP_W-1:0]  i_op,
    output logic                o_we,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [ADDR_W-1:0]   o_front_addr,
    output logic [ADDR_W-1:0]   o_back_addr,
    output logic [CNT_W-1:0]    o_count,
    output t_dq_ctl             o_ctl
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL = CNT_W'(DEPTH);

    logic [ADDR_W-1:0] r_front, n_front;
    logic [ADDR_W-1:0] r_back,  n_back;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_dq_status        w_status;
    logic              w_full;
    logic              w_empty;

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    assign w_full  = (r_count == FULL);
    assign w_empty = (r_count == '0);

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        w_we     = 1'b0;
        w_waddr  = r_back;
        w_status = ST_OK;
        unique case (t_dq_op'(i_op))
            OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_back;
                    n_back  = wrap_inc(r_back);
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_front = wrap_dec(r_front);
                    w_waddr = n_front;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_front = wrap_inc(r_front);
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_back  = wrap_dec(r_back);
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                n_count = '0;
            end
            default: begin
                // query and unused codes leave the queue alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    assign o_we         = i_accept && w_we;
    assign o_waddr      = w_waddr;
    assign o_front_addr = n_front;
    assign o_back_addr  = wrap_dec(n_back);
    assign o_count      = n_count;
    assign o_ctl        = '{nonempty: (n_count != '0), status: w_status};

endmodule

### design/double_ended_queue.sv
// top level of the bounded double-ended queue
// depends on dq_pkg, dq_ctrl and dq_ram

// usage
// - input channel (i_in_valid / o_in_ready / i_in_data) carries one operation
//   word: push back, push front, pop front, pop back, clear or query
// - output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   result word per operation: front and back elements with valid marks, the
//   element count and a status (ok, pop on empty, push on full)
// - an accepted word moves through the read stage and then the result register
// - throughput: one operation per cycle while the output drains; the pointer
//   update, store write and both store reads happen at the accepting edge, the
//   registered read data plus the result register form a two-stage output path
// - a read of a slot written at the same edge is forwarded inside the store
// - when the receiver stalls, the result register holds its word and the
//   read stage holds the next one; input ready then drops until the output
//   drains, so nothing is lost or repeated
// - synchronous active-low reset empties the queue (pointers and count to
//   zero) and clears both stage valids; the ring store is not cleared, since
//   only slots that were written are ever reported as valid
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH     = DQ_DEPTH,
    parameter int ELEM_BITS = DQ_ELEM_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dq_in  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dq_out o_out_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // handshake
    logic w_accept;
    logic w_s1_move;

    // pointer control to store
    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [ADDR_W-1:0]    w_front_addr;
    logic [ADDR_W-1:0]    w_back_addr;
    logic [CNT_W-1:0]     w_count;
    t_dq_ctl              w_ctl;
    logic [ELEM_BITS-1:0] w_wdata;
    logic [ELEM_BITS-1:0] w_rdata_f;
    logic [ELEM_BITS-1:0] w_rdata_b;

    // read stage: count and status ride alongside the store read
    logic             r_s1_valid, n_s1_valid;
    logic [CNT_W-1:0] r_s1_count;
    t_dq_ctl          r_s1_ctl;

    // result register
    logic    r_out_valid, n_out_valid;
    t_dq_out r_out;
    t_dq_out w_result;

    logic [DQ_VAL_W-1:0] w_front_val;
    logic [DQ_VAL_W-1:0] w_back_val;
    logic [DQ_CNT_W-1:0] w_count_out;

    // a stage-1 word moves on whenever the result register is free or draining
    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_move;
    assign w_accept   = i_in_valid && o_in_ready;

    // fit the 8-bit value field to the element width
    if (ELEM_BITS <= DQ_VAL_W) begin : g_wdata_narrow
        assign w_wdata = i_in_data.value[ELEM_BITS-1:0];
    end else begin : g_wdata_wide
        assign w_wdata = {{(ELEM_BITS-DQ_VAL_W){1'b0}}, i_in_data.value};
    end

    dq_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_op         (i_in_data.op),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_front_addr (w_front_addr),
        .o_back_addr  (w_back_addr),
        .o_count      (w_count),
        .o_ctl        (w_ctl)
    );

    dq_ram #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS),
        .ADDR_W    (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_accept),
        .i_raddr_f (w_front_addr),
        .i_raddr_b (w_back_addr),
        .o_rdata_f (w_rdata_f),
        .o_rdata_b (w_rdata_b)
    );

    // result fields are 8 bits wide whatever the element width
    if (ELEM_BITS >= DQ_VAL_W) begin : g_rdata_wide
        assign w_front_val = w_rdata_f[DQ_VAL_W-1:0];
        assign w_back_val  = w_rdata_b[DQ_VAL_W-1:0];
    end else begin : g_rdata_narrow
        assign w_front_val = {{(DQ_VAL_W-ELEM_BITS){1'b0}}, w_rdata_f};
        assign w_back_val  = {{(DQ_VAL_W-ELEM_BITS){1'b0}}, w_rdata_b};
    end

    if (CNT_W >= DQ_CNT_W) begin : g_cnt_wide
        assign w_count_out = r_s1_count[DQ_CNT_W-1:0];
    end else begin : g_cnt_narrow
        assign w_count_out = {{(DQ_CNT_W-CNT_W){1'b0}}, r_s1_count};
    end

    // empty queue reports zero elements
    always_comb begin
        w_result.front_value = r_s1_ctl.nonempty ? w_front_val : '0;
        w_result.front_valid = r_s1_ctl.nonempty;
        w_result.back_value  = r_s1_ctl.nonempty ? w_back_val : '0;
        w_result.back_valid  = r_s1_ctl.nonempty;
        w_result.count       = w_count_out;
        w_result.status      = r_s1_ctl.status;
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_move) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_count <= w_count;
            r_s1_ctl   <= w_ctl;
        end
        if (w_s1_move) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the count handed to the read stage never exceeds the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_count <= CNT_W'(DEPTH)))
        else $error("queue count above depth");

    // an accepted word always occupies the read stage next cycle
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted word lost before read stage");

    // a stalled read-stage word is never dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |=> r_s1_valid)
        else $error("read stage word dropped while stalled");

    // valid marks agree with each other and with the count, and status is a defined code
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.front_valid == o_out_data.back_valid)
                         && (o_out_data.front_valid == (o_out_data.count != '0))
                         && (o_out_data.status != 2'd3)))
        else $error("inconsistent result word");

endmodule
